FILE: rtl/core/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared constants, codes, types and the size-class function of the heap
// allocator.
// ----------------------------------------------------------------------------
package alc_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_SHIFT   = 12;
	localparam int MAX_PAGES    = 16;
	localparam int SIZE_CLASSES = 13;
	localparam int ALIGN_BYTES  = 8;
	localparam int MIN_BLOCK    = 3 * ALIGN_BYTES;
	localparam int HEAP_BYTES   = MAX_PAGES * PAGE_BYTES;
	localparam int HEAP_WORDS   = HEAP_BYTES / 4;
	localparam int WALK_LIMIT   = HEAP_BYTES / MIN_BLOCK + 1;

	localparam int WADDR_W = 14;
	localparam int OFF_W   = 16;
	localparam int END_W   = 17;
	localparam int NEED_W  = 17;
	localparam int SZ_W    = 18;
	localparam int PC_W    = 5;
	localparam int NP_W    = 6;
	localparam int CLS_W   = 4;
	localparam int STEP_W  = 12;

	localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_OOM    = 2'd1;
	localparam logic [1:0] STS_IGNORE = 2'd2;

	// one access to the heap memory
	typedef struct packed {
		logic               re;
		logic               we;
		logic [WADDR_W-1:0] addr;
		logic [31:0]        wdata;
	} mem_req_t;

	// one finished result from the sequencer
	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [1:0]  sts;
	} rsp_t;

	// size class: floor(log2(size/8)), capped at the last class
	function automatic logic [CLS_W-1:0] class_of(input logic [31:0] sz);
		logic [28:0]      q;
		logic [CLS_W-1:0] k;
		q = sz[31:3];
		k = '0;
		for (int i = 1; i < SIZE_CLASSES; i++) begin
			if ((q >> i) != 29'd0) k = CLS_W'(i);
		end
		return k;
	endfunction

endpackage

FILE: rtl/core/alc_heap_ram.sv
// ----------------------------------------------------------------------------
// alc_heap_ram
// Heap word memory: one read or write port, registered read data.
// ----------------------------------------------------------------------------
module alc_heap_ram (
	input  logic              clk,
	input  alc_pkg::mem_req_t req,
	output logic [31:0]       rdata
);

	logic [31:0] mem [alc_pkg::HEAP_WORDS];

	// write, and register the read word
	always_ff @(posedge clk) begin
		if (req.we) mem[req.addr] <= req.wdata;
		if (req.re) rdata <= mem[req.addr];
	end

endmodule

FILE: rtl/core/alc_ctrl.sv
// ----------------------------------------------------------------------------
// alc_ctrl
// Allocator sequencer: walks the size-class lists, splits, grows the heap,
// merges on free, and relinks blocks through read-modify-write on the heap.
// ----------------------------------------------------------------------------
module alc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       heap_base,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_op,
	input  logic [15:0]       in_req,
	input  logic [31:0]       in_addr,
	output alc_pkg::mem_req_t mem_req,
	input  logic [31:0]       mem_rdata,
	output alc_pkg::rsp_t     rsp,
	input  logic              rsp_ready
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_A_INIT = 5'd1;
	localparam logic [4:0] S_A_WALK = 5'd2;
	localparam logic [4:0] S_A_HDR  = 5'd3;
	localparam logic [4:0] S_A_NEXT = 5'd4;
	localparam logic [4:0] S_G_RD   = 5'd5;
	localparam logic [4:0] S_G_TAIL = 5'd6;
	localparam logic [4:0] S_G_CALC = 5'd7;
	localparam logic [4:0] S_P0     = 5'd8;
	localparam logic [4:0] S_P1     = 5'd9;
	localparam logic [4:0] S_P2     = 5'd10;
	localparam logic [4:0] S_P3     = 5'd11;
	localparam logic [4:0] S_F_CHK  = 5'd12;
	localparam logic [4:0] S_F_HDR  = 5'd13;
	localparam logic [4:0] S_F_FTR  = 5'd14;
	localparam logic [4:0] S_F_NXT  = 5'd15;
	localparam logic [4:0] S_F_PRD  = 5'd16;
	localparam logic [4:0] S_F_PRV  = 5'd17;
	localparam logic [4:0] S_F_PUT0 = 5'd18;
	localparam logic [4:0] S_F_PUT1 = 5'd19;
	localparam logic [4:0] S_U0     = 5'd20;
	localparam logic [4:0] S_U1     = 5'd21;
	localparam logic [4:0] S_U2     = 5'd22;
	localparam logic [4:0] S_U3     = 5'd23;
	localparam logic [4:0] S_U4     = 5'd24;
	localparam logic [4:0] S_L0     = 5'd25;
	localparam logic [4:0] S_L1     = 5'd26;
	localparam logic [4:0] S_L2     = 5'd27;
	localparam logic [4:0] S_DONE   = 5'd28;

	logic [4:0]                   state_q, ret_q;
	logic [alc_pkg::NEED_W-1:0]   need_q;
	logic [31:0]                  faddr_q;
	logic [alc_pkg::CLS_W-1:0]    k_q;
	logic [alc_pkg::OFF_W-1:0]    cur_q;
	logic [alc_pkg::STEP_W-1:0]   steps_q;
	logic [alc_pkg::OFF_W-1:0]    off_q, start_q;
	logic [alc_pkg::SZ_W-1:0]     sz_q, total_q, tail_q;
	logic                         has_tail_q;
	logic [31:0]                  w_q;
	logic [alc_pkg::PC_W-1:0]     pc_q;
	logic [alc_pkg::OFF_W-1:0]    u_off_q, u_p_q, u_s_q;
	logic [31:0]                  u_hdr_q;
	logic [alc_pkg::OFF_W-1:0]    l_off_q, l_h_q;
	logic [alc_pkg::SZ_W-1:0]     l_sz_q;
	logic [alc_pkg::CLS_W-1:0]    l_k_q;
	logic [alc_pkg::OFF_W-1:0]    heads_q [alc_pkg::SIZE_CLASSES];
	logic [31:0]                  res_addr_q;
	logic [1:0]                   res_sts_q;

	logic [alc_pkg::END_W-1:0]    end_w, end_off;
	logic [alc_pkg::OFF_W-1:0]    end16, cur_off, rd_sz16, u_s_off, u_p_off, l_h_off;
	logic [31:0]                  rd_sz, foff, ok_addr;
	logic                         walk_ok, fit, f_bad, hdr_ok, nb_ok, pv_ok, tail_ok;
	logic [alc_pkg::SZ_W-1:0]     nxt, nxt_room, rem, more, grow_sz;
	logic                         nxt_in, split, pages_ok;
	logic [alc_pkg::NP_W-1:0]     np_w;
	logic [alc_pkg::CLS_W-1:0]    need_cls, l_cls, u_cls;
	logic [alc_pkg::NEED_W-1:0]   need_raw;

	// decode helpers
	assign end_w    = {pc_q, {alc_pkg::PAGE_SHIFT{1'b0}}};
	assign end16    = end_w[alc_pkg::OFF_W-1:0];
	assign end_off  = end_w - alc_pkg::END_W'(off_q);
	assign cur_off  = {cur_q[alc_pkg::OFF_W-1:3], 3'b000};
	assign rd_sz    = mem_rdata & alc_pkg::SIZE_MASK;
	assign rd_sz16  = rd_sz[alc_pkg::OFF_W-1:0];
	assign walk_ok  = cur_q[0] && (steps_q < alc_pkg::STEP_W'(alc_pkg::WALK_LIMIT));
	assign fit      = rd_sz >= 32'(need_q);
	assign foff     = faddr_q - heap_base - 32'd4;
	assign f_bad    = (faddr_q == 32'd0) || (foff[2:0] != 3'd0) || (foff >= 32'(end_w));
	assign hdr_ok   = mem_rdata[0] && (rd_sz >= 32'(alc_pkg::MIN_BLOCK))
	               && (rd_sz <= 32'(end_off));
	assign nxt      = alc_pkg::SZ_W'(off_q) + sz_q;
	assign nxt_in   = nxt < alc_pkg::SZ_W'(end_w);
	assign nxt_room = alc_pkg::SZ_W'(end_w) - nxt;
	assign nb_ok    = !mem_rdata[0] && (rd_sz >= 32'(alc_pkg::MIN_BLOCK))
	               && (rd_sz <= 32'(nxt_room));
	assign pv_ok    = !mem_rdata[0] && (rd_sz >= 32'(alc_pkg::MIN_BLOCK))
	               && (rd_sz <= 32'(off_q));
	assign tail_ok  = !mem_rdata[0] && (rd_sz >= 32'(alc_pkg::MIN_BLOCK))
	               && (rd_sz <= 32'(end_w));
	assign rem      = sz_q - alc_pkg::SZ_W'(need_q);
	assign split    = (sz_q >= alc_pkg::SZ_W'(need_q))
	               && (rem >= alc_pkg::SZ_W'(alc_pkg::MIN_BLOCK));
	assign more     = (alc_pkg::SZ_W'(need_q) > tail_q) ?
	                  alc_pkg::SZ_W'(need_q) - tail_q : '0;
	assign np_w     = alc_pkg::NP_W'((more + alc_pkg::SZ_W'(alc_pkg::PAGE_BYTES - 1))
	                  >> alc_pkg::PAGE_SHIFT);
	assign pages_ok = np_w <= (alc_pkg::NP_W'(alc_pkg::MAX_PAGES) - alc_pkg::NP_W'(pc_q));
	assign grow_sz  = {np_w, {alc_pkg::PAGE_SHIFT{1'b0}}} + tail_q;
	assign need_cls = alc_pkg::class_of(32'(need_q));
	assign l_cls    = alc_pkg::class_of(32'(l_sz_q));
	assign u_cls    = alc_pkg::class_of(u_hdr_q & alc_pkg::SIZE_MASK);
	assign u_p_off  = {u_p_q[alc_pkg::OFF_W-1:3], 3'b000};
	assign u_s_off  = {u_s_q[alc_pkg::OFF_W-1:3], 3'b000};
	assign l_h_off  = {l_h_q[alc_pkg::OFF_W-1:3], 3'b000};
	assign ok_addr  = heap_base + 32'(off_q) + 32'd4;
	assign need_raw = (alc_pkg::NEED_W'(in_req) + alc_pkg::NEED_W'(15))
	               & ~alc_pkg::NEED_W'(7);

	assign in_ready  = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_DONE);
	assign rsp.addr  = res_addr_q;
	assign rsp.sts   = res_sts_q;

	// heap memory access for the current step
	always_comb begin
		logic [alc_pkg::OFF_W-1:0] a;
		a = '0;
		mem_req = '0;
		case (state_q)
			S_A_WALK: begin
				mem_req.re = walk_ok;
				a = cur_off;
			end
			S_A_HDR: begin
				mem_req.re = !fit;
				a = cur_off + 16'd8;
			end
			S_G_RD: begin
				mem_req.re = (pc_q != '0);
				a = end16 - 16'd4;
			end
			S_F_CHK: begin
				mem_req.re = !f_bad;
				a = foff[alc_pkg::OFF_W-1:0];
			end
			S_F_HDR: begin
				mem_req.re = hdr_ok;
				a = off_q + rd_sz16 - 16'd4;
			end
			S_F_FTR: begin
				mem_req.re = (mem_rdata == w_q) && nxt_in;
				a = nxt[alc_pkg::OFF_W-1:0];
			end
			S_F_PRD: begin
				mem_req.re = (off_q != '0);
				a = off_q - 16'd4;
			end
			S_P0: begin
				mem_req.we = 1'b1;
				a = off_q;
				mem_req.wdata = split ? (32'(need_q) & alc_pkg::SIZE_MASK) | 32'd1
				                      : (32'(sz_q) & alc_pkg::SIZE_MASK) | 32'd1;
			end
			S_P1: begin
				mem_req.we = 1'b1;
				a = split ? off_q + alc_pkg::OFF_W'(need_q) - 16'd4
				          : off_q + alc_pkg::OFF_W'(sz_q) - 16'd4;
				mem_req.wdata = split ? (32'(need_q) & alc_pkg::SIZE_MASK) | 32'd1
				                      : (32'(sz_q) & alc_pkg::SIZE_MASK) | 32'd1;
			end
			S_P2: begin
				mem_req.we = 1'b1;
				a = off_q + alc_pkg::OFF_W'(need_q);
				mem_req.wdata = 32'(rem) & alc_pkg::SIZE_MASK;
			end
			S_P3: begin
				mem_req.we = 1'b1;
				a = off_q + alc_pkg::OFF_W'(sz_q) - 16'd4;
				mem_req.wdata = 32'(rem) & alc_pkg::SIZE_MASK;
			end
			S_F_PUT0: begin
				mem_req.we = 1'b1;
				a = start_q;
				mem_req.wdata = 32'(total_q) & alc_pkg::SIZE_MASK;
			end
			S_F_PUT1: begin
				mem_req.we = 1'b1;
				a = start_q + alc_pkg::OFF_W'(total_q) - 16'd4;
				mem_req.wdata = 32'(total_q) & alc_pkg::SIZE_MASK;
			end
			S_U0: begin
				mem_req.re = 1'b1;
				a = u_off_q;
			end
			S_U1: begin
				mem_req.re = 1'b1;
				a = u_off_q + 16'd4;
			end
			S_U2: begin
				mem_req.re = 1'b1;
				a = u_off_q + 16'd8;
			end
			S_U3: begin
				mem_req.we = u_p_q[0];
				a = u_p_off + 16'd8;
				mem_req.wdata = 32'(mem_rdata[alc_pkg::OFF_W-1:0]);
			end
			S_U4: begin
				mem_req.we = u_s_q[0];
				a = u_s_off + 16'd4;
				mem_req.wdata = 32'(u_p_q);
			end
			S_L0: begin
				mem_req.we = 1'b1;
				a = l_off_q + 16'd4;
				mem_req.wdata = 32'd0;
			end
			S_L1: begin
				mem_req.we = 1'b1;
				a = l_off_q + 16'd8;
				mem_req.wdata = 32'(l_h_q);
			end
			S_L2: begin
				mem_req.we = l_h_q[0];
				a = l_h_off + 16'd4;
				mem_req.wdata = 32'(l_off_q | 16'd1);
			end
			default: begin
				mem_req = '0;
			end
		endcase
		mem_req.addr = a[alc_pkg::OFF_W-1:2];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			pc_q    <= '0;
			for (int i = 0; i < alc_pkg::SIZE_CLASSES; i++) heads_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						faddr_q <= in_addr;
						need_q  <= (need_raw < alc_pkg::NEED_W'(alc_pkg::MIN_BLOCK)) ?
						           alc_pkg::NEED_W'(alc_pkg::MIN_BLOCK) : need_raw;
						state_q <= (in_op == alc_pkg::OP_ALLOC) ? S_A_INIT : S_F_CHK;
					end
				end
				// first-fit walk from the request's class upward
				S_A_INIT: begin
					k_q     <= need_cls;
					cur_q   <= heads_q[need_cls];
					steps_q <= '0;
					state_q <= S_A_WALK;
				end
				S_A_WALK: begin
					if (walk_ok) begin
						state_q <= S_A_HDR;
					end else if (k_q == alc_pkg::CLS_W'(alc_pkg::SIZE_CLASSES - 1)) begin
						state_q <= S_G_RD;
					end else begin
						k_q     <= k_q + 1'b1;
						cur_q   <= heads_q[k_q + 1'b1];
						steps_q <= '0;
					end
				end
				S_A_HDR: begin
					if (fit) begin
						off_q   <= cur_off;
						sz_q    <= rd_sz[alc_pkg::SZ_W-1:0];
						u_off_q <= cur_off;
						ret_q   <= S_P0;
						state_q <= S_U0;
					end else begin
						state_q <= S_A_NEXT;
					end
				end
				S_A_NEXT: begin
					cur_q   <= mem_rdata[alc_pkg::OFF_W-1:0];
					steps_q <= steps_q + 1'b1;
					state_q <= S_A_WALK;
				end
				// grow the heap, absorbing a free last block
				S_G_RD: begin
					has_tail_q <= 1'b0;
					tail_q     <= '0;
					start_q    <= end16;
					state_q    <= (pc_q != '0) ? S_G_TAIL : S_G_CALC;
				end
				S_G_TAIL: begin
					if (tail_ok) begin
						has_tail_q <= 1'b1;
						tail_q     <= rd_sz[alc_pkg::SZ_W-1:0];
						start_q    <= end16 - rd_sz16;
					end
					state_q <= S_G_CALC;
				end
				S_G_CALC: begin
					if (!pages_ok) begin
						res_addr_q <= 32'd0;
						res_sts_q  <= alc_pkg::STS_OOM;
						state_q    <= S_DONE;
					end else begin
						pc_q    <= pc_q + alc_pkg::PC_W'(np_w);
						sz_q    <= grow_sz;
						off_q   <= start_q;
						u_off_q <= start_q;
						ret_q   <= S_P0;
						state_q <= has_tail_q ? S_U0 : S_P0;
					end
				end
				// place: mark used, split off a free remainder
				S_P0: state_q <= S_P1;
				S_P1: begin
					res_addr_q <= ok_addr;
					res_sts_q  <= alc_pkg::STS_OK;
					state_q    <= split ? S_P2 : S_DONE;
				end
				S_P2: state_q <= S_P3;
				S_P3: begin
					l_off_q <= off_q + alc_pkg::OFF_W'(need_q);
					l_sz_q  <= rem;
					ret_q   <= S_DONE;
					state_q <= S_L0;
				end
				// free: validate, merge neighbors, relink
				S_F_CHK: begin
					off_q <= foff[alc_pkg::OFF_W-1:0];
					if (f_bad) begin
						res_addr_q <= 32'd0;
						res_sts_q  <= alc_pkg::STS_IGNORE;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_F_HDR;
					end
				end
				S_F_HDR: begin
					w_q  <= mem_rdata;
					sz_q <= rd_sz[alc_pkg::SZ_W-1:0];
					if (hdr_ok) begin
						state_q <= S_F_FTR;
					end else begin
						res_addr_q <= 32'd0;
						res_sts_q  <= alc_pkg::STS_IGNORE;
						state_q    <= S_DONE;
					end
				end
				S_F_FTR: begin
					start_q <= off_q;
					total_q <= sz_q;
					if (mem_rdata != w_q) begin
						res_addr_q <= 32'd0;
						res_sts_q  <= alc_pkg::STS_IGNORE;
						state_q    <= S_DONE;
					end else begin
						state_q <= nxt_in ? S_F_NXT : S_F_PRD;
					end
				end
				S_F_NXT: begin
					if (nb_ok) begin
						total_q <= total_q + rd_sz[alc_pkg::SZ_W-1:0];
						u_off_q <= nxt[alc_pkg::OFF_W-1:0];
						ret_q   <= S_F_PRD;
						state_q <= S_U0;
					end else begin
						state_q <= S_F_PRD;
					end
				end
				S_F_PRD: state_q <= (off_q != '0) ? S_F_PRV : S_F_PUT0;
				S_F_PRV: begin
					if (pv_ok) begin
						start_q <= off_q - rd_sz16;
						total_q <= total_q + rd_sz[alc_pkg::SZ_W-1:0];
						u_off_q <= off_q - rd_sz16;
						ret_q   <= S_F_PUT0;
						state_q <= S_U0;
					end else begin
						state_q <= S_F_PUT0;
					end
				end
				S_F_PUT0: state_q <= S_F_PUT1;
				S_F_PUT1: begin
					l_off_q    <= start_q;
					l_sz_q     <= total_q;
					res_addr_q <= 32'd0;
					res_sts_q  <= alc_pkg::STS_OK;
					ret_q      <= S_DONE;
					state_q    <= S_L0;
				end
				// unlink: read header and links, then patch neighbors or head
				S_U0: state_q <= S_U1;
				S_U1: begin
					u_hdr_q <= mem_rdata;
					state_q <= S_U2;
				end
				S_U2: begin
					u_p_q   <= mem_rdata[alc_pkg::OFF_W-1:0];
					state_q <= S_U3;
				end
				S_U3: begin
					u_s_q <= mem_rdata[alc_pkg::OFF_W-1:0];
					if (!u_p_q[0]) heads_q[u_cls] <= mem_rdata[alc_pkg::OFF_W-1:0];
					state_q <= S_U4;
				end
				S_U4: state_q <= ret_q;
				// link at the front of the block's class list
				S_L0: begin
					l_k_q   <= l_cls;
					l_h_q   <= heads_q[l_cls];
					state_q <= S_L1;
				end
				S_L1: state_q <= S_L2;
				S_L2: begin
					heads_q[l_k_q] <= l_off_q | 16'd1;
					state_q        <= ret_q;
				end
				S_DONE: begin
					if (rsp_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pages_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= alc_pkg::PC_W'(alc_pkg::MAX_PAGES))
		else $error("page count past limit");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.re && mem_req.we))
		else $error("read and write in one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("sequencer idle after accept");

	a_oom_null: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.sts != alc_pkg::STS_OK)) |-> (rsp.addr == 32'd0))
		else $error("failed result carries an address");

endmodule

FILE: rtl/core/segregated_free_list_allocator.sv
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Heap allocator with boundary tags and segregated free lists held in one
// heap word memory; holds the base register and the result register.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          contents
//  s_*       in   tvalid/tready      tuser: op; tdata: request_size, free_addr
//  m_*       out  tvalid/tready      tdata: payload_addr; tuser: status
//  cfg_*     in   cfg_wen            heap_base
//
//  One word at a time. Allocate walks the class lists and skips list nodes,
//  then unlinks the block found, places it and relinks any remainder; growing
//  the heap may first absorb a free last block. Free is either ignored, or
//  merges each free neighbor and relinks the result. Each step makes at most
//  one access to the single heap memory port.
//  Reset clears lists and page count at once.
//  A waiting result sits in the output register while the next word enters.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] request_size, [47:16] free_addr
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] payload_addr
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic [31:0]       base_q;
	alc_pkg::mem_req_t mem_req;
	logic [31:0]       mem_rdata;
	alc_pkg::rsp_t     rsp;
	logic              rsp_ready;
	logic              m_valid_q;
	logic [31:0]       m_addr_q;
	logic [1:0]        m_sts_q;

	// base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= '0;
		else if (cfg_wen) base_q <= cfg_wdata;
	end

	alc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.heap_base (base_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_req    (s_tdata[15:0]),
		.in_addr   (s_tdata[47:16]),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.rsp       (rsp),
		.rsp_ready (rsp_ready)
	);

	alc_heap_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// result register: load when empty or being drained
	assign rsp_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			m_valid_q <= rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp.valid) begin
			m_addr_q <= rsp.addr;
			m_sts_q  <= rsp.sts;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_addr_q;
	assign m_tuser  = m_sts_q;

endmodule
